/* sv/slm_pkg.sv */
// shared constants, register codes and control types of the stereo level meter
package slm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int COEF_W     = 16;
  localparam int STRIDE_W   = 7;
  localparam int MAX_STRIDE = 64;
  localparam int FULL_SCALE = 32768;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_RELEASE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VU_ATTACK        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VU_RELEASE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RMS_WEIGHT       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCKPEAK_WEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_STRIDE     = 3'd5;

  localparam logic [COEF_W-1:0]   RST_PEAK_RELEASE     = 16'd62587;
  localparam logic [COEF_W-1:0]   RST_VU_ATTACK        = 16'd27525;
  localparam logic [COEF_W-1:0]   RST_VU_RELEASE       = 16'd55050;
  localparam logic [COEF_W-1:0]   RST_RMS_WEIGHT       = 16'd51118;
  localparam logic [COEF_W-1:0]   RST_BLOCKPEAK_WEIGHT = 16'd14418;
  localparam logic [STRIDE_W-1:0] RST_BLOCK_STRIDE     = 7'd12;

  // accumulator widths
  localparam int SQ_W       = 31;  // one square, up to 2^30
  localparam int SQSUM_W    = 37;
  localparam int MONO_SUM_W = 23;
  localparam int ABS_SUM_W  = 22;
  localparam int DIFF_SUM_W = 23;

  // bit-serial divider and root
  localparam int DIV_NUM_W  = SQSUM_W;
  localparam int DIV_DEN_W  = STRIDE_W;
  localparam int DIV_STEPS  = DIV_NUM_W;
  localparam int SQRT_IN_W  = 32;
  localparam int ROOT_W     = 16;
  localparam int SQRT_STEPS = SQRT_IN_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [COEF_W-1:0] peak_release;
    logic [COEF_W-1:0] vu_attack;
    logic [COEF_W-1:0] vu_release;
    logic [COEF_W-1:0] rms_weight;
    logic [COEF_W-1:0] blockpeak_weight;
  } cfg_t;

  typedef struct packed {
    logic                load;
    logic                mul;
    logic                acc;
    logic                div_start;
    logic                div_step;
    logic                sqrt_start;
    logic                sqrt_step;
    logic                tgt;
    logic                tsum;
    logic                vu1;
    logic                vu2;
    logic [STRIDE_W-1:0] n;
  } ctrl_t;

endpackage

/* sv/slm_if.sv */
// sample and level channel interfaces of the stereo level meter
interface slm_sample_if;
  import slm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface slm_level_if;
  import slm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic        [LEVEL_W-1:0]  peak_left;
  logic        [LEVEL_W-1:0]  peak_right;
  logic        [LEVEL_W-1:0]  vu_left;
  logic        [LEVEL_W-1:0]  vu_right;
  logic signed [SAMPLE_W-1:0] block_mean;
  logic        [LEVEL_W-1:0]  block_energy;
  logic        [LEVEL_W-1:0]  block_transient;
  logic                       block_end;

  modport source (output valid, output peak_left, output peak_right, output vu_left,
                  output vu_right, output block_mean, output block_energy,
                  output block_transient, output block_end, input ready);
  modport sink   (input valid, input peak_left, input peak_right, input vu_left,
                  input vu_right, input block_mean, input block_energy,
                  input block_transient, input block_end, output ready);
endinterface

/* sv/stereo_level_meter_ballistics_core.sv */
// top level of the stereo level meter: sequencer, registers, lanes, merge stage and result register
// a sample inside a block passes the load, multiply, accumulate and done states to a valid result;
// the sample that ends a block also runs the 37-step divider, the 16-step root, target and vu states
// the shared step sequencer takes a new sample only in idle, after the last result is loaded
// a waiting result sits in its own register while the next sample is taken
// rst clears levels, sums and the count and loads register defaults at once
module stereo_level_meter_ballistics_core (
  input  logic                              clk,
  input  logic                              rst,
  slm_sample_if.sink                        sample_in,
  slm_level_if.source                       level_out,
  input  logic                              cfg_write,
  input  logic [slm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import slm_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_ACC     = 4'd2;
  localparam logic [3:0] S_DSTART  = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_SQSTART = 4'd5;
  localparam logic [3:0] S_SQRT    = 4'd6;
  localparam logic [3:0] S_TGT     = 4'd7;
  localparam logic [3:0] S_TSUM    = 4'd8;
  localparam logic [3:0] S_VU1     = 4'd9;
  localparam logic [3:0] S_VU2     = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STEP_W-1:0]   step_cnt;
  logic [STRIDE_W-1:0] count;
  logic [STRIDE_W-1:0] count_inc;
  logic [STRIDE_W-1:0] stride_eff;
  logic                block_end;
  logic [STRIDE_W-1:0] block_stride;
  cfg_t                cfg;
  ctrl_t               ctrl;
  logic                accept;
  logic                out_free;
  logic                done_load;

  logic [LEVEL_W-1:0]         peak_l;
  logic [LEVEL_W-1:0]         peak_r;
  logic [LEVEL_W-1:0]         vu_l;
  logic [LEVEL_W-1:0]         vu_r;
  logic signed [SAMPLE_W-1:0] mean;
  logic [LEVEL_W-1:0]         energy;
  logic [LEVEL_W-1:0]         transient;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_release     <= RST_PEAK_RELEASE;
      cfg.vu_attack        <= RST_VU_ATTACK;
      cfg.vu_release       <= RST_VU_RELEASE;
      cfg.rms_weight       <= RST_RMS_WEIGHT;
      cfg.blockpeak_weight <= RST_BLOCKPEAK_WEIGHT;
      block_stride         <= RST_BLOCK_STRIDE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PEAK_RELEASE:     cfg.peak_release     <= cfg_data;
        REG_VU_ATTACK:        cfg.vu_attack        <= cfg_data;
        REG_VU_RELEASE:       cfg.vu_release       <= cfg_data;
        REG_RMS_WEIGHT:       cfg.rms_weight       <= cfg_data;
        REG_BLOCKPEAK_WEIGHT: cfg.blockpeak_weight <= cfg_data;
        REG_BLOCK_STRIDE:     block_stride         <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero stride acts as one, anything above the maximum as the maximum
  assign stride_eff = (block_stride == '0) ? STRIDE_W'(1) :
                      (block_stride > STRIDE_W'(MAX_STRIDE)) ? STRIDE_W'(MAX_STRIDE) :
                      block_stride;
  assign count_inc  = count + STRIDE_W'(1);

  assign sample_in.ready = (state == S_IDLE);
  assign accept          = sample_in.valid && (state == S_IDLE);
  assign out_free        = !level_out.valid || level_out.ready;
  assign done_load       = (state == S_DONE) && out_free;

  always_comb begin
    ctrl.load       = accept;
    ctrl.mul        = (state == S_MUL);
    ctrl.acc        = (state == S_ACC);
    ctrl.div_start  = (state == S_DSTART);
    ctrl.div_step   = (state == S_DIV);
    ctrl.sqrt_start = (state == S_SQSTART);
    ctrl.sqrt_step  = (state == S_SQRT);
    ctrl.tgt        = (state == S_TGT);
    ctrl.tsum       = (state == S_TSUM);
    ctrl.vu1        = (state == S_VU1);
    ctrl.vu2        = (state == S_VU2);
    ctrl.n          = count;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (sample_in.valid) state_next = S_MUL;
      S_MUL:     state_next = S_ACC;
      S_ACC:     state_next = block_end ? S_DSTART : S_DONE;
      S_DSTART:  state_next = S_DIV;
      S_DIV:     if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = S_SQSTART;
      S_SQSTART: state_next = S_SQRT;
      S_SQRT:    if (step_cnt == STEP_W'(SQRT_STEPS - 1)) state_next = S_TGT;
      S_TGT:     state_next = S_TSUM;
      S_TSUM:    state_next = S_VU1;
      S_VU1:     state_next = S_VU2;
      S_VU2:     state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      count     <= '0;
      block_end <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV || state == S_SQRT) begin
        step_cnt <= (state_next == state) ? step_cnt + STEP_W'(1) : '0;
      end else begin
        step_cnt <= '0;
      end
      if (state == S_MUL) begin
        count     <= count_inc;
        block_end <= (count_inc >= stride_eff);
      end
      if (state == S_VU2) begin
        count <= '0;
      end
    end
  end

  slm_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .sample (sample_in.left_sample),
    .peak   (peak_l),
    .vu     (vu_l)
  );

  slm_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .sample (sample_in.right_sample),
    .peak   (peak_r),
    .vu     (vu_r)
  );

  slm_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .left_sample  (sample_in.left_sample),
    .right_sample (sample_in.right_sample),
    .mean         (mean),
    .energy       (energy),
    .transient    (transient)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_out.valid <= 1'b0;
    end else if (done_load) begin
      level_out.valid <= 1'b1;
    end else if (level_out.ready) begin
      level_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      level_out.peak_left       <= peak_l;
      level_out.peak_right      <= peak_r;
      level_out.vu_left         <= vu_l;
      level_out.vu_right        <= vu_r;
      level_out.block_mean      <= block_end ? mean : '0;
      level_out.block_energy    <= block_end ? energy : '0;
      level_out.block_transient <= block_end ? transient : '0;
      level_out.block_end       <= block_end;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= STRIDE_W'(MAX_STRIDE))
    else $error("block sample count above maximum stride");

  a_block_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (level_out.valid && !level_out.block_end) |->
      (level_out.block_mean == '0 && level_out.block_energy == '0 &&
       level_out.block_transient == '0))
    else $error("block fields nonzero outside a block end");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && level_out.valid && !level_out.ready) |=> state == S_DONE)
    else $error("result loaded over a waiting transaction");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> step_cnt < STEP_W'(SQRT_STEPS))
    else $error("root step count overran");

  a_block_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTART) |-> count != '0)
    else $error("block end with empty count");

endmodule

/* sv/slm_div.sv */
// bit-serial restoring divider by the block sample count
module slm_div (
  input  logic                           clk,
  input  logic                           start,
  input  logic                           step,
  input  logic [slm_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [slm_pkg::DIV_DEN_W-1:0]  divisor,
  output logic [slm_pkg::DIV_NUM_W-1:0]  quotient
);
  import slm_pkg::*;

  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   rem_t;
  logic                 fits;

  assign rem_t = {rem, quo[DIV_NUM_W-1]};
  assign fits  = rem_t >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (step) begin
      rem <= fits ? DIV_DEN_W'(rem_t - {1'b0, divisor}) : rem_t[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

/* sv/slm_lane.sv */
// one channel lane: decaying peak, block squares and peak, rms root and vu ballistics
module slm_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  slm_pkg::ctrl_t                    ctrl,
  input  slm_pkg::cfg_t                     cfg,
  input  logic signed [slm_pkg::SAMPLE_W-1:0] sample,
  output logic        [slm_pkg::LEVEL_W-1:0]  peak,
  output logic        [slm_pkg::LEVEL_W-1:0]  vu
);
  import slm_pkg::*;

  logic [LEVEL_W-1:0]   mag;
  logic [SQ_W-1:0]      sq_prod;
  logic [LEVEL_W-1:0]   decay;
  logic [LEVEL_W-1:0]   peak_level;
  logic [LEVEL_W-1:0]   vu_level;
  logic [SQSUM_W-1:0]   square_sum;
  logic [LEVEL_W-1:0]   block_peak;
  logic [DIV_NUM_W-1:0] ms_quo;

  logic [SQRT_IN_W-1:0] sq_val;
  logic [ROOT_W+1:0]    sq_rem;
  logic [ROOT_W-1:0]    root;
  logic [ROOT_W+3:0]    rem_t;
  logic [ROOT_W+3:0]    trial;
  logic                 root_fits;

  logic [31:0]          sq_full;
  logic [31:0]          decay_full;
  logic [31:0]          p_rms;
  logic [31:0]          p_bpk;
  logic [32:0]          t_sum;
  logic [16:0]          t_shift;
  logic [LEVEL_W-1:0]   target;
  logic                 rise_c;
  logic                 rise;
  logic [31:0]          m1;
  logic [31:0]          m2;
  logic [32:0]          blend;
  logic [COEF_W:0]      rel_comp;

  assign sq_full    = 32'(mag) * 32'(mag);
  assign decay_full = 32'(peak_level) * 32'(cfg.peak_release);

  assign rem_t     = {sq_rem, sq_val[SQRT_IN_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign root_fits = rem_t >= trial;

  assign t_sum    = 33'(p_rms) + 33'(p_bpk);
  assign t_shift  = t_sum[32:16];
  assign rise_c   = target > vu_level;
  assign rel_comp = 17'(FULL_SCALE * 2) - {1'b0, cfg.vu_release};
  assign blend    = 33'(m1) + 33'(m2);

  slm_div u_div (
    .clk      (clk),
    .start    (ctrl.div_start),
    .step     (ctrl.div_step),
    .dividend (square_sum),
    .divisor  (ctrl.n),
    .quotient (ms_quo)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= sample[SAMPLE_W-1] ? LEVEL_W'(~sample + 16'sd1) : LEVEL_W'(sample);
    end
    if (ctrl.mul) begin
      sq_prod <= sq_full[SQ_W-1:0];
      decay   <= decay_full[31:16];
    end
    if (ctrl.sqrt_start) begin
      sq_val <= {1'b0, ms_quo[SQRT_IN_W-2:0]};
      sq_rem <= '0;
      root   <= '0;
    end else if (ctrl.sqrt_step) begin
      sq_val <= {sq_val[SQRT_IN_W-3:0], 2'b00};
      sq_rem <= root_fits ? (ROOT_W+2)'(rem_t - trial) : rem_t[ROOT_W+1:0];
      root   <= {root[ROOT_W-2:0], root_fits};
    end
    if (ctrl.tgt) begin
      p_rms <= 32'(root) * 32'(cfg.rms_weight);
      p_bpk <= 32'(block_peak) * 32'(cfg.blockpeak_weight);
    end
    if (ctrl.tsum) begin
      target <= (t_shift > 17'(FULL_SCALE)) ? LEVEL_W'(FULL_SCALE) : t_shift[LEVEL_W-1:0];
    end
    if (ctrl.vu1) begin
      rise <= rise_c;
      m1   <= rise_c ? 32'(target - vu_level) * 32'(cfg.vu_attack)
                     : 32'(vu_level) * 32'(cfg.vu_release);
      m2   <= 32'(target) * 32'(rel_comp);
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level <= '0;
      vu_level   <= '0;
      square_sum <= '0;
      block_peak <= '0;
    end else begin
      if (ctrl.acc) begin
        peak_level <= (mag > decay) ? mag : decay;
        square_sum <= square_sum + SQSUM_W'(sq_prod);
        if (mag > block_peak) begin
          block_peak <= mag;
        end
      end
      if (ctrl.vu2) begin
        vu_level   <= rise ? vu_level + m1[31:16] : blend[31:16];
        square_sum <= '0;
        block_peak <= '0;
      end
    end
  end

  assign peak = peak_level;
  assign vu   = vu_level;

endmodule

/* sv/slm_merge.sv */
// merging stage: mono average, block sums and their clamped means
module slm_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  slm_pkg::ctrl_t                      ctrl,
  input  logic signed [slm_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [slm_pkg::SAMPLE_W-1:0] right_sample,
  output logic signed [slm_pkg::SAMPLE_W-1:0] mean,
  output logic        [slm_pkg::LEVEL_W-1:0]  energy,
  output logic        [slm_pkg::LEVEL_W-1:0]  transient
);
  import slm_pkg::*;

  logic [SAMPLE_W:0]     pair_sum;
  logic [SAMPLE_W-1:0]   mono;
  logic [SAMPLE_W-1:0]   last_mono;
  logic [SAMPLE_W:0]     mono_ext;
  logic [SAMPLE_W:0]     mono_abs;
  logic [SAMPLE_W:0]     diff;
  logic [SAMPLE_W:0]     diff_abs;
  logic [MONO_SUM_W-1:0] mono_sum;
  logic [ABS_SUM_W-1:0]  abs_sum;
  logic [DIFF_SUM_W-1:0] diff_sum;
  logic [MONO_SUM_W-1:0] mono_mag;
  logic                  mono_neg;
  logic [DIV_NUM_W-1:0]  mean_quo;
  logic [DIV_NUM_W-1:0]  energy_quo;
  logic [DIV_NUM_W-1:0]  trans_quo;
  logic [SAMPLE_W-1:0]   mean_neg;

  // floor of half the pair sum is an arithmetic shift
  assign pair_sum = {left_sample[SAMPLE_W-1], left_sample}
                  + {right_sample[SAMPLE_W-1], right_sample};
  assign mono_ext = {mono[SAMPLE_W-1], mono};
  assign mono_abs = mono[SAMPLE_W-1] ? ~mono_ext + 17'd1 : mono_ext;
  assign diff     = mono_ext - {last_mono[SAMPLE_W-1], last_mono};
  assign diff_abs = diff[SAMPLE_W] ? ~diff + 17'd1 : diff;
  assign mono_mag = mono_sum[MONO_SUM_W-1] ? ~mono_sum + 23'd1 : mono_sum;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mono <= pair_sum[SAMPLE_W:1];
    end
    if (ctrl.div_start) begin
      mono_neg <= mono_sum[MONO_SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mono <= '0;
      mono_sum  <= '0;
      abs_sum   <= '0;
      diff_sum  <= '0;
    end else begin
      if (ctrl.mul) begin
        mono_sum  <= mono_sum + {{(MONO_SUM_W-SAMPLE_W){mono[SAMPLE_W-1]}}, mono};
        abs_sum   <= abs_sum + ABS_SUM_W'(mono_abs);
        diff_sum  <= diff_sum + DIFF_SUM_W'(diff_abs);
        last_mono <= mono;
      end
      if (ctrl.vu2) begin
        mono_sum <= '0;
        abs_sum  <= '0;
        diff_sum <= '0;
      end
    end
  end

  slm_div u_div_mean (
    .clk      (clk),
    .start    (ctrl.div_start),
    .step     (ctrl.div_step),
    .dividend (DIV_NUM_W'(mono_mag)),
    .divisor  (ctrl.n),
    .quotient (mean_quo)
  );

  slm_div u_div_energy (
    .clk      (clk),
    .start    (ctrl.div_start),
    .step     (ctrl.div_step),
    .dividend (DIV_NUM_W'(abs_sum)),
    .divisor  (ctrl.n),
    .quotient (energy_quo)
  );

  slm_div u_div_trans (
    .clk      (clk),
    .start    (ctrl.div_start),
    .step     (ctrl.div_step),
    .dividend (DIV_NUM_W'(diff_sum)),
    .divisor  (ctrl.n),
    .quotient (trans_quo)
  );

  // truncating signed mean from the magnitude quotient
  assign mean_neg = ~mean_quo[SAMPLE_W-1:0] + 16'd1;

  always_comb begin
    if (mono_neg) begin
      mean = (mean_quo > DIV_NUM_W'(FULL_SCALE)) ? 16'sh8000 : $signed(mean_neg);
    end else begin
      mean = (mean_quo > DIV_NUM_W'(FULL_SCALE - 1)) ? 16'sh7fff
                                                     : $signed(mean_quo[SAMPLE_W-1:0]);
    end
    energy    = (energy_quo > DIV_NUM_W'(FULL_SCALE)) ? LEVEL_W'(FULL_SCALE)
                                                      : energy_quo[LEVEL_W-1:0];
    transient = (trans_quo > DIV_NUM_W'(FULL_SCALE)) ? LEVEL_W'(FULL_SCALE)
                                                     : trans_quo[LEVEL_W-1:0];
  end

endmodule
